>>> sv/fqplm_pkg.sv
// fqplm_pkg: shared types, codes and defaults of the four-queue priority list manager.
// No dependencies; every other file of the block but fqplm_store refers to it by scoped names.
package fqplm_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int PRIORITY_MAX_DEF = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_HEAD   = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] EXEC_READY   = 2'd0;
  localparam logic [1:0] EXEC_BLOCKED = 2'd1;
  localparam logic [1:0] EXEC_OTHER   = 2'd2;
  localparam logic [1:0] EXEC_SPARE   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_INVALID   = 2'd2;
  localparam logic [1:0] STATUS_QUEUED    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] slot;
    logic [3:0] prio;
    logic       suspended;
    logic [1:0] exec_state;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       head_valid;
    logic [3:0] head_slot;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EVAL,
    ST_LINK2,
    ST_DONE
  } state_t;

endpackage

>>> sv/fqplm_store.sv
// fqplm_store: per-slot link and priority memories, one write and one registered read each.
// Depends on nothing but its parameters.
module fqplm_store #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = $clog2(ENTRIES),
  parameter int LINK_W  = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [LINK_W-1:0] rd_link,
  output logic [3:0]        rd_prio,
  input  logic              link_we,
  input  logic [IDX_W-1:0]  link_waddr,
  input  logic [LINK_W-1:0] link_wdata,
  input  logic              prio_we,
  input  logic [IDX_W-1:0]  prio_waddr,
  input  logic [3:0]        prio_wdata
);

  logic [LINK_W-1:0] link_mem [ENTRIES];
  logic [3:0]        prio_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (prio_we) begin
      prio_mem[prio_waddr] <= prio_wdata;
    end
    rd_link <= link_mem[rd_addr];
    rd_prio <= prio_mem[rd_addr];
  end

endmodule

>>> sv/fqplm_seq.sv
// fqplm_seq: sequencer that walks a queue one slot per cycle through one compare unit,
// and owns queue heads, tails and queued flags. Depends on fqplm_pkg and fqplm_store ports.
module fqplm_seq #(
  parameter int ENTRIES      = 16,
  parameter int PRIORITY_MAX = 9,
  parameter int IDX_W        = $clog2(ENTRIES),
  parameter int LINK_W       = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fqplm_pkg::req_t     req,
  output logic                res_valid,
  input  logic                res_ready,
  output fqplm_pkg::rsp_t     res,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [LINK_W-1:0]   rd_link,
  input  logic [3:0]          rd_prio,
  output logic                link_we,
  output logic [IDX_W-1:0]    link_waddr,
  output logic [LINK_W-1:0]   link_wdata,
  output logic                prio_we,
  output logic [IDX_W-1:0]    prio_waddr,
  output logic [3:0]          prio_wdata
);

  localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

  fqplm_pkg::state_t state, state_next;
  fqplm_pkg::req_t   cur;

  logic [LINK_W-1:0]  head [4];
  logic [LINK_W-1:0]  head_next [4];
  logic [LINK_W-1:0]  tail [4];
  logic [LINK_W-1:0]  tail_next [4];
  logic [ENTRIES-1:0] queued, queued_next;
  logic [IDX_W-1:0]   x, x_next;
  logic [IDX_W-1:0]   prev, prev_next;
  logic               prev_nil, prev_nil_next;
  logic [IDX_W-1:0]   pend, pend_next;
  logic [1:0]         status, status_next;

  logic [1:0]         q;
  logic               invalid;
  logic               blocked;
  logic               slot_ok;
  logic [IDX_W-1:0]   s_idx;
  logic [LINK_W-1:0]  s_link;
  logic [3:0]         p_sat;
  logic               lnk_nil;
  logic [LINK_W-1:0]  hq;

  assign q       = {cur.suspended, cur.exec_state[0]};
  assign invalid = (cur.exec_state != fqplm_pkg::EXEC_READY) &&
                   (cur.exec_state != fqplm_pkg::EXEC_BLOCKED);
  assign blocked = (cur.exec_state == fqplm_pkg::EXEC_BLOCKED);
  assign slot_ok = (32'(cur.slot) < ENTRIES);
  assign s_idx   = IDX_W'(cur.slot);
  assign s_link  = LINK_W'(cur.slot);
  assign p_sat   = (32'(cur.prio) > PRIORITY_MAX) ? 4'(PRIORITY_MAX) : cur.prio;
  assign lnk_nil = (rd_link == NIL);
  assign hq      = head[q];

  assign prio_waddr = s_idx;
  assign prio_wdata = p_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fqplm_pkg::ST_IDLE;
      queued   <= '0;
      for (int i = 0; i < 4; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      state    <= state_next;
      queued   <= queued_next;
      for (int i = 0; i < 4; i++) begin
        head[i] <= head_next[i];
        tail[i] <= tail_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == fqplm_pkg::ST_IDLE && req_valid) begin
      cur <= req;
    end
    x        <= x_next;
    prev     <= prev_next;
    prev_nil <= prev_nil_next;
    pend     <= pend_next;
    status   <= status_next;
  end

  always_comb begin
    state_next    = state;
    queued_next   = queued;
    head_next     = head;
    tail_next     = tail;
    x_next        = x;
    prev_next     = prev;
    prev_nil_next = prev_nil;
    pend_next     = pend;
    status_next   = status;
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    rd_addr       = x;
    link_we       = 1'b0;
    link_waddr    = s_idx;
    link_wdata    = NIL;
    prio_we       = 1'b0;

    unique case (state)
      fqplm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = fqplm_pkg::ST_DISPATCH;
        end
      end

      fqplm_pkg::ST_DISPATCH: begin
        rd_addr       = IDX_W'(hq);
        x_next        = IDX_W'(hq);
        prev_nil_next = 1'b1;
        status_next   = fqplm_pkg::STATUS_OK;
        state_next    = fqplm_pkg::ST_DONE;
        if (invalid) begin
          status_next = fqplm_pkg::STATUS_INVALID;
        end else begin
          unique case (cur.operation)
            fqplm_pkg::OP_INSERT: begin
              if (!slot_ok) begin
                status_next = fqplm_pkg::STATUS_NOT_FOUND;
              end else if (queued[s_idx]) begin
                status_next = fqplm_pkg::STATUS_QUEUED;
              end else begin
                queued_next[s_idx] = 1'b1;
                prio_we            = 1'b1;
                link_we            = 1'b1;   // new slot starts as end of list
                if (hq == NIL || (blocked && tail[q] == NIL)) begin
                  head_next[q] = s_link;
                  tail_next[q] = s_link;
                end else if (blocked) begin
                  pend_next    = IDX_W'(tail[q]);
                  tail_next[q] = s_link;
                  state_next   = fqplm_pkg::ST_LINK2;
                end else begin
                  state_next = fqplm_pkg::ST_EVAL;
                end
              end
            end
            fqplm_pkg::OP_REMOVE: begin
              if (!slot_ok || hq == NIL) begin
                status_next = fqplm_pkg::STATUS_NOT_FOUND;
              end else begin
                state_next = fqplm_pkg::ST_EVAL;
              end
            end
            default: begin
              // head query and the unused code report the head only
            end
          endcase
        end
      end

      fqplm_pkg::ST_EVAL: begin
        // rd_link/rd_prio belong to x; fetch its successor for the next step
        rd_addr       = IDX_W'(rd_link);
        x_next        = IDX_W'(rd_link);
        prev_next     = x;
        prev_nil_next = 1'b0;
        if (cur.operation == fqplm_pkg::OP_REMOVE) begin
          if (x == s_idx) begin
            queued_next[s_idx] = 1'b0;
            state_next         = fqplm_pkg::ST_DONE;
            if (prev_nil) begin
              head_next[q] = rd_link;
              if (lnk_nil) begin
                tail_next[q] = NIL;
              end
            end else begin
              link_we    = 1'b1;
              link_waddr = prev;
              link_wdata = rd_link;
              if (tail[q] == s_link) begin
                tail_next[q] = LINK_W'(prev);
              end
            end
          end else if (lnk_nil) begin
            status_next = fqplm_pkg::STATUS_NOT_FOUND;
            state_next  = fqplm_pkg::ST_DONE;
          end
        end else begin
          if (p_sat < rd_prio) begin
            link_we    = 1'b1;
            link_waddr = s_idx;
            link_wdata = LINK_W'(x);
            if (prev_nil) begin
              head_next[q] = s_link;
              state_next   = fqplm_pkg::ST_DONE;
            end else begin
              pend_next  = prev;
              state_next = fqplm_pkg::ST_LINK2;
            end
          end else if (lnk_nil) begin
            link_we      = 1'b1;
            link_waddr   = x;
            link_wdata   = s_link;
            tail_next[q] = s_link;
            state_next   = fqplm_pkg::ST_DONE;
          end
        end
      end

      fqplm_pkg::ST_LINK2: begin
        link_we    = 1'b1;
        link_waddr = pend;
        link_wdata = s_link;
        state_next = fqplm_pkg::ST_DONE;
      end

      fqplm_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = fqplm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fqplm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status     = status;
    res.head_valid = !invalid && (hq != NIL);
    res.head_slot  = res.head_valid ? 4'(hq) : 4'd0;
  end

endmodule

>>> sv/four_queue_priority_list_manager_unit.sv
// Path: an accepted request passes ST_DISPATCH, one ST_EVAL step per slot visited in the queue
// walk and ST_LINK2 where a second link write is needed, then waits in ST_DONE for the response register.
// Throughput: one request at a time; the next is taken only once the sequencer is back in ST_IDLE, and
// the walk through the link memory, one slot per cycle, sets the pace.
// A new request is taken while the previous response waits in its register.
// Reset (rst, synchronous): all queues empty, no slot queued, no response pending.
module four_queue_priority_list_manager_unit #(
  parameter int ENTRIES      = fqplm_pkg::ENTRIES_DEF,
  parameter int PRIORITY_MAX = fqplm_pkg::PRIORITY_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  fqplm_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fqplm_pkg::rsp_t rsp
);

  // The link and priority memories get no reset; a slot's entries are written on insert first.
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LINK_W = $clog2(ENTRIES + 1);

  // memory port between sequencer and store
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] rd_link;
  logic [3:0]        rd_prio;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              prio_we;
  logic [IDX_W-1:0]  prio_waddr;
  logic [3:0]        prio_wdata;

  // finished result from the sequencer, before the response register
  logic            res_valid;
  logic            res_ready;
  fqplm_pkg::rsp_t res;

  fqplm_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .LINK_W  (LINK_W)
  ) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .rd_link    (rd_link),
    .rd_prio    (rd_prio),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .prio_we    (prio_we),
    .prio_waddr (prio_waddr),
    .prio_wdata (prio_wdata)
  );

  fqplm_seq #(
    .ENTRIES      (ENTRIES),
    .PRIORITY_MAX (PRIORITY_MAX),
    .IDX_W        (IDX_W),
    .LINK_W       (LINK_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .rd_addr    (rd_addr),
    .rd_link    (rd_link),
    .rd_prio    (rd_prio),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .prio_we    (prio_we),
    .prio_waddr (prio_waddr),
    .prio_wdata (prio_wdata)
  );

  // Response register: loads when empty or being drained this cycle.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

>>> sv/fqplm_checker.sv
// fqplm_checker: port-level assertions for four_queue_priority_list_manager_unit.
// Depends on fqplm_pkg; attached to the top level by the bind at the end of this file.
module fqplm_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input fqplm_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input fqplm_pkg::rsp_t rsp
);

  // one request at a time: the block drops ready right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous one still in work");

  a_invalid_no_head: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == fqplm_pkg::STATUS_INVALID) |-> !rsp.head_valid)
    else $error("invalid state response reports a head");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.head_valid) |-> (rsp.head_slot == 4'd0))
    else $error("empty queue response carries a nonzero head slot");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind four_queue_priority_list_manager_unit fqplm_checker u_fqplm_checker (.*);

>>> test/tb.sv
// tb: self-checking bench for four_queue_priority_list_manager_unit.
// Depends on fqplm_pkg (request/response structs and codes) and the unit RTL.
// Predicts each response with a linked-list model kept inside a scoreboard class.
module tb;

  localparam int NUM_SLOTS      = fqplm_pkg::ENTRIES_DEF;
  localparam int PRIO_CEIL      = fqplm_pkg::PRIORITY_MAX_DEF;
  localparam int RANDOM_COUNT   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = NUM_SLOTS + 8;

  // Scoreboard: owns the expected-response queue and a mirror of the
  // four linked queues (ready, blocked, ready-suspended, blocked-suspended).
  class prio_queue_scoreboard;
    localparam logic [4:0] NO_LINK = 5'd16;

    logic [4:0]       link_nxt[NUM_SLOTS];
    logic [3:0]       slot_prio[NUM_SLOTS];
    bit               queued_flag[NUM_SLOTS];
    logic [1:0]       home_q[NUM_SLOTS];
    logic [4:0]       q_head[4];
    logic [4:0]       q_tail[4];
    fqplm_pkg::rsp_t  expected_rsp[$];
    int               mismatch_count;
    int               rsp_count;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        link_nxt[i]    = NO_LINK;
        slot_prio[i]   = '0;
        queued_flag[i] = 1'b0;
        home_q[i]      = '0;
      end
      for (int i = 0; i < 4; i++) begin
        q_head[i] = NO_LINK;
        q_tail[i] = NO_LINK;
      end
      mismatch_count = 0;
      rsp_count      = 0;
    endfunction

    // ready queues: sorted by priority, ties stay in arrival order
    function void link_ordered(logic [1:0] q, logic [3:0] s, logic [3:0] p);
      logic [4:0] cur;
      logic [4:0] nx;
      bit         done;
      link_nxt[s] = NO_LINK;
      if (q_head[q] == NO_LINK) begin
        q_head[q] = {1'b0, s};
        q_tail[q] = {1'b0, s};
        return;
      end
      if (p < slot_prio[q_head[q][3:0]]) begin
        link_nxt[s] = q_head[q];
        q_head[q]   = {1'b0, s};
        return;
      end
      cur  = q_head[q];
      done = 1'b0;
      while (!done) begin
        nx = link_nxt[cur[3:0]];
        if (nx == NO_LINK) begin
          link_nxt[cur[3:0]] = {1'b0, s};
          q_tail[q]          = {1'b0, s};
          done               = 1'b1;
        end else if (p < slot_prio[nx[3:0]]) begin
          link_nxt[s]        = nx;
          link_nxt[cur[3:0]] = {1'b0, s};
          done               = 1'b1;
        end else begin
          cur = nx;
        end
      end
    endfunction

    function void link_tail(logic [1:0] q, logic [3:0] s);
      link_nxt[s] = NO_LINK;
      if (q_head[q] == NO_LINK || q_tail[q] == NO_LINK)
        q_head[q] = {1'b0, s};
      else
        link_nxt[q_tail[q][3:0]] = {1'b0, s};
      q_tail[q] = {1'b0, s};
    endfunction

    function bit unlink(logic [1:0] q, logic [3:0] s);
      logic [4:0] prev;
      logic [4:0] nx;
      if (q_head[q] == NO_LINK) return 1'b0;
      if (q_head[q] == {1'b0, s}) begin
        q_head[q] = link_nxt[s];
        if (q_head[q] == NO_LINK) q_tail[q] = NO_LINK;
        link_nxt[s] = NO_LINK;
        return 1'b1;
      end
      prev = q_head[q];
      forever begin
        nx = link_nxt[prev[3:0]];
        if (nx == NO_LINK) return 1'b0;
        if (nx == {1'b0, s}) begin
          link_nxt[prev[3:0]] = link_nxt[s];
          if (q_tail[q] == {1'b0, s}) q_tail[q] = prev;
          link_nxt[s] = NO_LINK;
          return 1'b1;
        end
        prev = nx;
      end
    endfunction

    function fqplm_pkg::rsp_t apply_list_op(fqplm_pkg::req_t r);
      fqplm_pkg::rsp_t o;
      logic [1:0]      q;
      logic [3:0]      p;
      o = '0;
      if (r.exec_state != fqplm_pkg::EXEC_READY && r.exec_state != fqplm_pkg::EXEC_BLOCKED) begin
        o.status = fqplm_pkg::STATUS_INVALID;
        return o;
      end
      q        = {r.suspended, r.exec_state[0]};
      o.status = fqplm_pkg::STATUS_OK;
      case (r.operation)
        fqplm_pkg::OP_INSERT: begin
          if (queued_flag[r.slot]) begin
            o.status = fqplm_pkg::STATUS_QUEUED;
          end else begin
            p = (r.prio > PRIO_CEIL) ? 4'(PRIO_CEIL) : r.prio;
            slot_prio[r.slot]   = p;
            queued_flag[r.slot] = 1'b1;
            home_q[r.slot]      = q;
            if (r.exec_state == fqplm_pkg::EXEC_READY) link_ordered(q, r.slot, p);
            else link_tail(q, r.slot);
          end
        end
        fqplm_pkg::OP_REMOVE: begin
          if (unlink(q, r.slot)) queued_flag[r.slot] = 1'b0;
          else o.status = fqplm_pkg::STATUS_NOT_FOUND;
        end
        default: ;
      endcase
      if (q_head[q] != NO_LINK) begin
        o.head_valid = 1'b1;
        o.head_slot  = q_head[q][3:0];
      end
      return o;
    endfunction

    function void note_request(fqplm_pkg::req_t r);
      expected_rsp.push_back(apply_list_op(r));
    endfunction

    task report(string msg);
      $display("mismatch @%0t rsp #%0d: %s", $time, rsp_count, msg);
      mismatch_count++;
    endtask

    task check_response(fqplm_pkg::rsp_t got);
      fqplm_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected response status=%0d head=%0d/%0d",
                         got.status, got.head_valid, got.head_slot));
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.head_valid !== want.head_valid)
          report($sformatf("head_valid %0d, want %0d", got.head_valid, want.head_valid));
        if (got.head_slot !== want.head_slot)
          report($sformatf("head_slot %0d, want %0d", got.head_slot, want.head_slot));
      end
      rsp_count++;
    endtask
  endclass

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  fqplm_pkg::req_t req;
  logic            rsp_valid;
  logic            rsp_ready;
  fqplm_pkg::rsp_t rsp;

  prio_queue_scoreboard sb = new();

  // Random-phase knobs, retuned every hundred requests.
  bit         idle_on;
  logic [1:0] focus_q;
  int         insert_pct;
  int         quiet_cycles;

  four_queue_priority_list_manager_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hang shows up as a long run of cycles without any handshake.
  // The slowest legal gap is sender idle + full list walk + receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic fqplm_pkg::req_t pack_request(logic [1:0] op, logic [3:0] s,
                                                   logic [3:0] p, logic su, logic [1:0] ex);
    fqplm_pkg::req_t r;
    r.operation  = op;
    r.slot       = s;
    r.prio       = p;
    r.suspended  = su;
    r.exec_state = ex;
    return r;
  endfunction

  // Inputs move on the falling edge only; the request is logged into the
  // scoreboard at the rising edge where valid and ready meet.
  task send_request(input fqplm_pkg::req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Park the request channel and hold off until every response is back.
  task drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic: inserts of free slots, removes of slots that
  // sit in the named queue. The rest hits duplicates, wrong queues, invalid
  // exec states, the spare opcode and out-of-range priorities.
  function automatic fqplm_pkg::req_t draw_request();
    fqplm_pkg::req_t r;
    int              roll;
    int              n;
    logic [3:0]      pick[NUM_SLOTS];
    logic [3:0]      s;
    logic [1:0]      q;
    r    = '0;
    roll = $urandom_range(0, 99);
    r.prio = 4'($urandom_range(0, 15));
    if (roll < 5) begin
      r.operation  = 2'($urandom_range(0, 3));
      r.slot       = 4'($urandom_range(0, 15));
      r.suspended  = 1'($urandom_range(0, 1));
      r.exec_state = ($urandom_range(0, 1) == 0) ? fqplm_pkg::EXEC_OTHER : fqplm_pkg::EXEC_SPARE;
      return r;
    end
    q = ($urandom_range(0, 99) < 70) ? focus_q : 2'($urandom_range(0, 3));
    if (roll < 10) begin
      r.operation = ($urandom_range(0, 1) == 0) ? fqplm_pkg::OP_HEAD : fqplm_pkg::OP_SPARE;
      r.slot      = 4'($urandom_range(0, 15));
    end else if (roll < 10 + insert_pct) begin
      r.operation = fqplm_pkg::OP_INSERT;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (!sb.queued_flag[i]) begin
          pick[n] = 4'(i);
          n++;
        end
      if (n > 0 && $urandom_range(0, 99) < 85) s = pick[$urandom_range(0, n - 1)];
      else s = 4'($urandom_range(0, 15));
      r.slot = s;
      roll = $urandom_range(0, 99);
      if (roll < 50) r.prio = 4'($urandom_range(0, 3));
      else if (roll < 90) r.prio = 4'($urandom_range(4, PRIO_CEIL));
      else r.prio = 4'($urandom_range(PRIO_CEIL + 1, 15));
    end else begin
      r.operation = fqplm_pkg::OP_REMOVE;
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (sb.queued_flag[i]) begin
          pick[n] = 4'(i);
          n++;
        end
      if (n > 0 && $urandom_range(0, 99) < 80) begin
        s = pick[$urandom_range(0, n - 1)];
        q = sb.home_q[s];
      end else begin
        s = 4'($urandom_range(0, 15));
      end
      r.slot = s;
    end
    r.suspended  = q[1];
    r.exec_state = q[0] ? fqplm_pkg::EXEC_BLOCKED : fqplm_pkg::EXEC_READY;
    return r;
  endfunction

  // Response side: random backpressure per response, burst phases included.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      sb.check_response(rsp);
    end
  end

  // Stimulus: directed list walk first, then randomized phases.
  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    idle_on    = 1'b1;
    focus_q    = 2'd0;
    insert_pct = 45;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty queue, ordered inserts with ties, saturated priority
    send_request(pack_request(fqplm_pkg::OP_HEAD,   4'd0,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd3,  4'd5,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd7,  4'd5,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd1,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd9,  4'd15, 1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd4,  4'd9,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd2,  4'd5,  1'b0, fqplm_pkg::EXEC_READY));
    // duplicates, same queue and another queue
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd3,  4'd1,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd3,  4'd1,  1'b0, fqplm_pkg::EXEC_BLOCKED));
    // blocked and suspended queues
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd10, 4'd2,  1'b0, fqplm_pkg::EXEC_BLOCKED));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd11, 4'd0,  1'b0, fqplm_pkg::EXEC_BLOCKED));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd12, 4'd3,  1'b1, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd13, 4'd8,  1'b1, fqplm_pkg::EXEC_BLOCKED));
    // wrong queue and never-queued slot
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd10, 4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd5,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    // unlink head, middle, tail, then append behind the new tail
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd1,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd2,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd4,  4'd0,  1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd15, 4'd12, 1'b0, fqplm_pkg::EXEC_READY));
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd11, 4'd0,  1'b0, fqplm_pkg::EXEC_BLOCKED));
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd14, 4'd6,  1'b0, fqplm_pkg::EXEC_BLOCKED));
    // invalid exec state, spare opcode
    send_request(pack_request(fqplm_pkg::OP_INSERT, 4'd8,  4'd4,  1'b0, fqplm_pkg::EXEC_OTHER));
    send_request(pack_request(fqplm_pkg::OP_REMOVE, 4'd3,  4'd0,  1'b1, fqplm_pkg::EXEC_SPARE));
    send_request(pack_request(fqplm_pkg::OP_SPARE,  4'd0,  4'd0,  1'b1, fqplm_pkg::EXEC_BLOCKED));
    send_request(pack_request(fqplm_pkg::OP_HEAD,   4'd0,  4'd0,  1'b1, fqplm_pkg::EXEC_READY));
    drain_responses();

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 100 == 0) begin
        idle_on    = ($urandom_range(0, 3) != 0);
        focus_q    = 2'($urandom_range(0, 3));
        insert_pct = $urandom_range(30, 60);
      end
      if (n % 250 == 249) drain_responses();
      send_request(draw_request());
    end

    drain_responses();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.expected_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
